/* hw/rtl/feistel_block_cipher_core_assert.svh */
// ----------------------------------------------------------------------------
// feistel block cipher core assertion macros
// Shared concurrent assertion forms for the core's checker.
// ----------------------------------------------------------------------------
`ifndef FEISTEL_BLOCK_CIPHER_CORE_ASSERT_SVH
`define FEISTEL_BLOCK_CIPHER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbc assertion failed");

// next-cycle implication, disabled during reset
`define FBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbc assertion failed");

`endif

/* hw/rtl/fbc_pkg.sv */
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared constants and types of the feistel block cipher core.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int KEY_BITS_DEF = 64;
   localparam int CELL_BITS    = 2;
   localparam int RK_BITS      = 32;
   localparam int DATA_BITS    = 64;
   localparam int ROUND_BITS   = 8;
   localparam int KIND_BITS    = 2;
   localparam int CSR_IDX_BITS = 2;

   // unit kinds
   localparam logic [KIND_BITS-1:0] KIND_BYTE  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_PAIR  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_BLOCK = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROUNDS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIR    = 2'd2;

   localparam logic [ROUND_BITS-1:0] ROUNDS_RESET = 8'd16;

   typedef struct packed {
      logic load;
      logic shift;
      logic dir;
   } cell_ctl_type;

   typedef struct packed {
      logic dir;
      logic narrow;
   } round_ctl_type;

endpackage

/* hw/rtl/feistel_block_cipher_core.sv */
// ----------------------------------------------------------------------------
// feistel_block_cipher_core
// Feistel cipher over 8-byte blocks and byte pairs; lone bytes get a key XOR mask.
// ----------------------------------------------------------------------------
//   channel  ports                                       direction
//   req      req_valid/req_ready, unit_kind, data_in      in
//   rsp      rsp_valid/rsp_ready, data_out, kind_out      out
//   csr      csr_we, csr_index, csr_wdata                 in, write only
//
// a block or pair passes round_count rounds from acceptance to the result
// register: one round per cycle through the single round unit, round keys
// taken from a ring of two-bit key cells that rotates once per round.
// lone bytes and undefined kinds run no rounds.
// a new word is taken in the cycle the previous one retires into the
// output register; a stalled output holds only the finishing word.
// synchronous reset sets control and settings (16 rounds), not data; no clear pass.
// ----------------------------------------------------------------------------
module feistel_block_cipher_core #(
   parameter int KEY_BITS = fbc_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fbc_pkg::KIND_BITS-1:0]     req_unit_kind,
   input  logic [fbc_pkg::DATA_BITS-1:0]     req_data_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fbc_pkg::DATA_BITS-1:0]     rsp_data_out,
   output logic [fbc_pkg::KIND_BITS-1:0]     rsp_kind_out,
   input  logic                              csr_we,
   input  logic [fbc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [KEY_BITS-1:0]               csr_wdata
);

   localparam int CELLS = KEY_BITS / fbc_pkg::CELL_BITS;
   localparam int SH_W  = $clog2(CELLS);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type                         state_ff, state_in;
   logic [KEY_BITS-1:0]               key_ff, key_in;
   logic [fbc_pkg::ROUND_BITS-1:0]    rounds_ff, rounds_in;
   logic                              dir_ff, dir_in;
   logic [fbc_pkg::ROUND_BITS-1:0]    cnt_ff, cnt_in;
   logic [fbc_pkg::KIND_BITS-1:0]     kind_ff, kind_in;
   logic [fbc_pkg::RK_BITS-1:0]       a_ff, a_in;
   logic [fbc_pkg::RK_BITS-1:0]       b_ff, b_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [fbc_pkg::DATA_BITS-1:0]     rsp_data_ff, rsp_data_in;
   logic [fbc_pkg::KIND_BITS-1:0]     rsp_kind_ff, rsp_kind_in;

   logic                              out_free;
   logic                              finish;
   logic                              accept;
   logic                              running;
   logic [fbc_pkg::ROUND_BITS-1:0]    last_round;
   logic [SH_W-1:0]                   dec_sh;
   logic [2*KEY_BITS-1:0]             key_dbl;
   logic [KEY_BITS-1:0]               key_load;
   logic [KEY_BITS-1:0]               ring;
   logic [7:0]                        byte_mask;
   logic [fbc_pkg::RK_BITS-1:0]       a_rnd, b_rnd;
   fbc_pkg::cell_ctl_type             cell_ctl;
   fbc_pkg::round_ctl_type            rnd_ctl;

   logic [fbc_pkg::CELL_BITS-1:0]     cell_q [CELLS];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_RUN) && (cnt_ff == '0) && out_free;
   assign running   = (state_ff == ST_RUN) && (cnt_ff != '0);
   assign req_ready = (state_ff == ST_IDLE) || finish;
   assign accept    = req_valid && req_ready;

   // decrypt starts from the last round key: rotation by 2*(rounds-1) mod key width
   assign last_round = rounds_ff - 8'd1;
   assign dec_sh     = last_round[SH_W-1:0];
   assign key_dbl    = {key_ff, key_ff} << {dec_sh, 1'b0};
   assign key_load   = dir_ff ? key_dbl[2*KEY_BITS-1:KEY_BITS] : key_ff;

   assign cell_ctl.load  = accept;
   assign cell_ctl.shift = running;
   assign cell_ctl.dir   = dir_ff;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      fbc_key_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .load_val (key_load[i*fbc_pkg::CELL_BITS +: fbc_pkg::CELL_BITS]),
         .from_lo  (cell_q[(i + CELLS - 1) % CELLS]),
         .from_hi  (cell_q[(i + 1) % CELLS]),
         .q        (cell_q[i])
      );
      assign ring[i*fbc_pkg::CELL_BITS +: fbc_pkg::CELL_BITS] = cell_q[i];
   end

   assign rnd_ctl.dir    = dir_ff;
   assign rnd_ctl.narrow = (kind_ff == fbc_pkg::KIND_PAIR);

   fbc_round_unit u_round (
      .ctl    (rnd_ctl),
      .rkey   (ring[fbc_pkg::RK_BITS-1:0]),
      .a      (a_ff),
      .b      (b_ff),
      .a_next (a_rnd),
      .b_next (b_rnd)
   );

   assign byte_mask = key_ff[7:0] ^ key_ff[15:8] ^ key_ff[23:16] ^ rounds_ff;

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      rounds_in    = rounds_ff;
      dir_in       = dir_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;

      if (csr_we) begin
         case (csr_index)
            fbc_pkg::CSR_KEY:    key_in    = csr_wdata;
            fbc_pkg::CSR_ROUNDS: rounds_in = csr_wdata[fbc_pkg::ROUND_BITS-1:0];
            fbc_pkg::CSR_DIR:    dir_in    = csr_wdata[0];
            default:             ;
         endcase
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind_ff;
         if (kind_ff == fbc_pkg::KIND_PAIR) begin
            rsp_data_in = {48'd0, b_ff[7:0], a_ff[7:0]};
         end else begin
            rsp_data_in = {b_ff, a_ff};
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         state_in = ST_RUN;
         kind_in  = req_unit_kind;
         case (req_unit_kind)
            fbc_pkg::KIND_BYTE: begin
               a_in   = {24'd0, req_data_in[7:0] ^ byte_mask};
               b_in   = '0;
               cnt_in = '0;
            end
            fbc_pkg::KIND_PAIR: begin
               a_in   = {24'd0, req_data_in[7:0]};
               b_in   = {24'd0, req_data_in[15:8]};
               cnt_in = rounds_ff;
            end
            fbc_pkg::KIND_BLOCK: begin
               a_in   = req_data_in[31:0];
               b_in   = req_data_in[63:32];
               cnt_in = rounds_ff;
            end
            default: begin
               // undefined kind passes through
               a_in   = req_data_in[31:0];
               b_in   = req_data_in[63:32];
               cnt_in = '0;
            end
         endcase
      end else if (finish) begin
         state_in = ST_IDLE;
      end else if (running) begin
         a_in   = a_rnd;
         b_in   = b_rnd;
         cnt_in = cnt_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ff       <= '0;
         rounds_ff    <= fbc_pkg::ROUNDS_RESET;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         rounds_ff    <= rounds_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      kind_ff     <= kind_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_kind_out = rsp_kind_ff;

endmodule

/* hw/rtl/fbc_key_cell.sv */
// ----------------------------------------------------------------------------
// fbc_key_cell
// One two-bit slice of the key ring; rotates with its neighbors each round.
// ----------------------------------------------------------------------------
module fbc_key_cell (
   input  logic                           clock,
   input  fbc_pkg::cell_ctl_type          ctl,
   input  logic [fbc_pkg::CELL_BITS-1:0]  load_val,
   input  logic [fbc_pkg::CELL_BITS-1:0]  from_lo,
   input  logic [fbc_pkg::CELL_BITS-1:0]  from_hi,
   output logic [fbc_pkg::CELL_BITS-1:0]  q
);

   logic [fbc_pkg::CELL_BITS-1:0] cell_ff;
   logic [fbc_pkg::CELL_BITS-1:0] cell_in;

   // encrypt rotates left (take from lower cell), decrypt rotates right
   always_comb begin
      cell_in = cell_ff;
      if (ctl.load) begin
         cell_in = load_val;
      end else if (ctl.shift) begin
         cell_in = ctl.dir ? from_hi : from_lo;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign q = cell_ff;

endmodule

/* hw/rtl/fbc_round_unit.sv */
// ----------------------------------------------------------------------------
// fbc_round_unit
// One feistel round: byte-mixing round function and half swap.
// ----------------------------------------------------------------------------
module fbc_round_unit (
   input  fbc_pkg::round_ctl_type        ctl,
   input  logic [fbc_pkg::RK_BITS-1:0]   rkey,
   input  logic [fbc_pkg::RK_BITS-1:0]   a,
   input  logic [fbc_pkg::RK_BITS-1:0]   b,
   output logic [fbc_pkg::RK_BITS-1:0]   a_next,
   output logic [fbc_pkg::RK_BITS-1:0]   b_next
);

   logic [fbc_pkg::RK_BITS-1:0] src;
   logic [fbc_pkg::RK_BITS-1:0] other;
   logic [fbc_pkg::RK_BITS-1:0] x;
   logic [fbc_pkg::RK_BITS-1:0] f;
   logic [fbc_pkg::RK_BITS-1:0] mask;
   logic [fbc_pkg::RK_BITS-1:0] t;

   always_comb begin
      src   = ctl.dir ? b : a;
      other = ctl.dir ? a : b;
      x     = src ^ rkey;
      f     = {x[23:16] ^ x[31:24], x[15:8] ^ x[31:24],
               x[23:16] ^ x[31:24], x[7:0] ^ x[31:24]};
      // byte pair keeps only the low byte of each half
      mask  = ctl.narrow ? 32'h0000_00ff : 32'hffff_ffff;
      t     = (other ^ f) & mask;
      if (ctl.dir) begin
         a_next = b;
         b_next = t;
      end else begin
         a_next = t;
         b_next = a;
      end
   end

endmodule

/* hw/rtl/fbc_checker.sv */
// ----------------------------------------------------------------------------
// fbc_checker
// Port-level checks on the feistel block cipher core, bound to the top level.
// ----------------------------------------------------------------------------
`include "feistel_block_cipher_core_assert.svh"

module fbc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [fbc_pkg::DATA_BITS-1:0]  rsp_data_out,
   input logic [fbc_pkg::KIND_BITS-1:0]  rsp_kind_out
);

   // a stalled result word holds
   `FBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out) && $stable(rsp_kind_out))

   // lone byte results carry nothing above the byte
   `FBC_ASSERT_NOW(a_byte_upper, clock, reset, rsp_valid && (rsp_kind_out == fbc_pkg::KIND_BYTE), rsp_data_out[63:8] == 56'd0)

   // byte pair results carry nothing above the pair
   `FBC_ASSERT_NOW(a_pair_upper, clock, reset, rsp_valid && (rsp_kind_out == fbc_pkg::KIND_PAIR), rsp_data_out[63:16] == 48'd0)

   // a ready core stays ready until a word arrives
   `FBC_ASSERT_NEXT(a_ready_holds, clock, reset, req_ready && !req_valid, req_ready)

endmodule

bind feistel_block_cipher_core fbc_checker u_fbc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_data_out (rsp_data_out),
   .rsp_kind_out (rsp_kind_out)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the feistel block cipher core: a local cipher
// model predicts every word, results are matched in order, with random idle
// cycles on both channels and key, round and direction changes between runs.
// ----------------------------------------------------------------------------
module tb_top;
   import fbc_pkg::*;

   localparam logic [KIND_BITS-1:0]    KIND_UNDEF   = 2'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED   = 2'd3;
   localparam int                      STALL_LIMIT  = 4000;
   localparam int                      DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [DATA_BITS-1:0] data;
      logic [KIND_BITS-1:0] kind;
   } cipher_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [KIND_BITS-1:0]      req_unit_kind = '0;
   logic [DATA_BITS-1:0]      req_data_in = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [DATA_BITS-1:0]      rsp_data_out;
   logic [KIND_BITS-1:0]      rsp_kind_out;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index = '0;
   logic [KEY_BITS_DEF-1:0]   csr_wdata = '0;

   // local copy of the cipher settings
   logic [63:0]               cfg_key = '0;
   logic [ROUND_BITS-1:0]     cfg_rounds = ROUNDS_RESET;
   logic                      cfg_dir = 1'b0;

   cipher_word_type           expected_words[$];
   int                        error_count = 0;
   int                        stall_cycles = 0;
   int                        idle_pct = 33;

   feistel_block_cipher_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_unit_kind (req_unit_kind),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_out  (rsp_data_out),
      .rsp_kind_out  (rsp_kind_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [31:0] round_subkey(input int idx);
      int          amt;
      logic [63:0] rot;
      amt = (idx * 2) % 64;
      rot = (amt == 0) ? cfg_key : ((cfg_key << amt) | (cfg_key >> (64 - amt)));
      return rot[31:0];
   endfunction

   function automatic logic [31:0] round_mix(input logic [31:0] half, input logic [31:0] sk);
      logic [31:0] x;
      x = half ^ sk;
      return {x[23:16] ^ x[31:24], x[15:8] ^ x[31:24],
              x[23:16] ^ x[31:24], x[7:0] ^ x[31:24]};
   endfunction

   // returns {right, left} after all rounds
   function automatic logic [63:0] feistel_rounds(input logic [31:0] left_in,
                                                  input logic [31:0] right_in,
                                                  input logic narrow);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] t;
      logic [31:0] mask;
      int          i;
      mask = narrow ? 32'h0000_00FF : 32'hFFFF_FFFF;
      a = left_in;
      b = right_in;
      if (!cfg_dir) begin
         for (i = 0; i < int'(cfg_rounds); i++) begin
            t = (b ^ round_mix(a, round_subkey(i))) & mask;
            b = a;
            a = t;
         end
      end else begin
         for (i = int'(cfg_rounds); i > 0; i--) begin
            t = (a ^ round_mix(b, round_subkey(i - 1))) & mask;
            a = b;
            b = t;
         end
      end
      return {b, a};
   endfunction

   function automatic cipher_word_type cipher_unit(input logic [KIND_BITS-1:0] kind,
                                                   input logic [DATA_BITS-1:0] data);
      cipher_word_type w;
      logic [63:0]     f;
      w.kind = kind;
      case (kind)
         KIND_BYTE: begin
            w.data = {56'd0, data[7:0] ^ cfg_key[7:0] ^ cfg_key[15:8]
                             ^ cfg_key[23:16] ^ cfg_rounds};
         end
         KIND_PAIR: begin
            f = feistel_rounds({24'd0, data[7:0]}, {24'd0, data[15:8]}, 1'b1);
            w.data = {48'd0, f[39:32], f[7:0]};
         end
         KIND_BLOCK: begin
            w.data = feistel_rounds(data[31:0], data[63:32], 1'b0);
         end
         default: begin
            w.data = data;
         end
      endcase
      return w;
   endfunction

   // ------------------------------------------------------------ channels

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      cipher_word_type exp_word;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word: data_out %h kind_out %0d",
                        $time, rsp_data_out, rsp_kind_out);
               error_count++;
            end else begin
               exp_word = expected_words.pop_front();
               if (rsp_data_out !== exp_word.data) begin
                  $display("%0t: data_out mismatch: expected %h actual %h",
                           $time, exp_word.data, rsp_data_out);
                  error_count++;
               end
               if (rsp_kind_out !== exp_word.kind) begin
                  $display("%0t: kind_out mismatch: expected %0d actual %0d",
                           $time, exp_word.kind, rsp_kind_out);
                  error_count++;
               end
            end
         end
         // watchdog: only counts while work is outstanding
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else if (req_valid || expected_words.size() != 0) begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
               $display("Verification failed");
               $finish;
            end
         end
      end
   end

   task automatic send_word(input logic [KIND_BITS-1:0] kind,
                            input logic [DATA_BITS-1:0] data);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid     <= 1'b1;
      req_unit_kind <= kind;
      req_data_in   <= data;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(cipher_unit(kind, data));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (int'(cfg_rounds) + 4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_KEY:    cfg_key = value;
         CSR_ROUNDS: cfg_rounds = value[ROUND_BITS-1:0];
         CSR_DIR:    cfg_dir = value[0];
         default:    ;
      endcase
   endtask

   task automatic set_cipher(input logic [63:0] key, input logic [7:0] rounds,
                             input logic dir);
      wait_idle();
      write_csr(CSR_KEY, key);
      write_csr(CSR_ROUNDS, {$urandom, 24'($urandom_range(0, 16777215)), rounds});
      write_csr(CSR_DIR, {$urandom, 24'($urandom_range(0, 16777215)), 7'd0, dir});
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // --------------------------------------------------------------- tests

   // writes to the unused index must not disturb the reset settings
   task automatic test_reset_defaults();
      wait_idle();
      write_csr(CSR_UNUSED, rand_word());
      send_word(KIND_BYTE, rand_word());
      send_word(KIND_PAIR, rand_word());
      send_word(KIND_BLOCK, rand_word());
      send_word(KIND_UNDEF, rand_word());
   endtask

   task automatic test_round_extremes();
      set_cipher('1, 8'd255, 1'b0);
      send_word(KIND_BLOCK, '1);
      send_word(KIND_PAIR, 64'hDEAD_BEEF_CAFE_A55A);
      set_cipher('1, 8'd255, 1'b1);
      send_word(KIND_BLOCK, '1);
      send_word(KIND_PAIR, '0);
      // zero rounds leaves blocks and pairs untouched
      set_cipher(rand_word(), 8'd0, 1'($urandom_range(0, 1)));
      send_word(KIND_BLOCK, rand_word());
      send_word(KIND_PAIR, rand_word());
      send_word(KIND_BYTE, rand_word());
   endtask

   task automatic test_unit_kinds();
      // round 0 uses the unrotated key
      set_cipher(64'h8000_0000_0000_0001, 8'd1, 1'b0);
      send_word(KIND_BLOCK, '0);
      send_word(KIND_BLOCK, '1);
      send_word(KIND_PAIR, 64'h0000_0000_0000_FFFF);
      send_word(KIND_BYTE, 64'h0000_0000_0000_00FF);
      set_cipher('0, 8'd2, 1'b1);
      send_word(KIND_UNDEF, '1);
      send_word(KIND_UNDEF, '0);
      // junk above the unit must be dropped
      send_word(KIND_BYTE, 64'hFFFF_FFFF_FFFF_FF00);
      send_word(KIND_BLOCK, '0);
   endtask

   task automatic test_random_traffic();
      int                   phase;
      int                   n;
      int                   count;
      logic [63:0]          key;
      logic [7:0]           rounds;
      logic [KIND_BITS-1:0] kind;
      for (phase = 0; phase < 24; phase++) begin
         case (phase)
            0:       key = '0;
            1:       key = '1;
            default: key = rand_word();
         endcase
         if (phase % 8 == 7) begin
            rounds = 8'd255;
            count  = 8;
         end else begin
            rounds = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 24));
            count  = 45;
         end
         set_cipher(key, rounds, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, rand_word());
         // a long stretch with both sides always ready
         idle_pct = (phase >= 10 && phase <= 12) ? 0 : 33;
         for (n = 0; n < count; n++) begin
            kind = ($urandom_range(0, 9) == 0) ? KIND_UNDEF : 2'($urandom_range(0, 2));
            send_word(kind, rand_word());
         end
      end
      idle_pct = 33;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_round_extremes();
      test_unit_kinds();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
